### rtl/cspr_pkg.sv
// Package for the circle span and point rasterizer.
// Holds the shared width and queue depth, the command code and the span order tables.
// No dependencies.
`default_nettype none

package cspr_pkg;

  // Default coordinate width of the centre fields
  localparam int CSPR_COORD_BITS = 16;

  // Depth of the command queue between front and back end
  localparam int CSPR_QUEUE_DEPTH = 2;

  // Command kinds as carried through the queue
  typedef enum logic {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } op_t;

  // Outline order: eight points per step, bit k belongs to point k.
  // SEL picks offset b when set, offset a when clear; NEG subtracts.
  localparam logic [7:0] PT_COL_SEL = 8'b1010_1010;
  localparam logic [7:0] PT_COL_NEG = 8'b1100_1100;
  localparam logic [7:0] PT_ROW_SEL = 8'b0101_0101;
  localparam logic [7:0] PT_ROW_NEG = 8'b1111_0000;
  localparam logic [2:0] PT_LAST    = 3'd7;

  // Fill order: four spans per step, bit k belongs to span k
  localparam logic [3:0] SP_W_SEL   = 4'b1001;
  localparam logic [3:0] SP_ROW_SEL = 4'b0110;
  localparam logic [3:0] SP_ROW_NEG = 4'b1100;
  localparam logic [1:0] SP_LAST    = 2'd3;

endpackage

`default_nettype wire

### rtl/cspr_if.sv
// Channel interfaces of the circle span and point rasterizer.
// Input item channel and span result channel; depends on cspr_pkg.
`default_nettype none

interface cspr_in_if
  import cspr_pkg::*;
#(
  parameter int COORD_BITS = CSPR_COORD_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic        [COORD_BITS-2:0] circle_radius;
  logic                         filled;

  modport source (
    output valid, kind, center_x, center_y, circle_radius, filled,
    input  ready
  );
  modport sink (
    input  valid, kind, center_x, center_y, circle_radius, filled,
    output ready
  );
endinterface

interface cspr_out_if
  import cspr_pkg::*;
#(
  parameter int COORD_BITS = CSPR_COORD_BITS
) ();
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] x_left;
  logic signed [COORD_BITS:0] x_right;
  logic signed [COORD_BITS:0] span_row;
  logic                       valid_res;
  logic                       last;

  modport source (
    output valid, x_left, x_right, span_row, valid_res, last,
    input  ready
  );
  modport sink (
    input  valid, x_left, x_right, span_row, valid_res, last,
    output ready
  );
endinterface

`default_nettype wire

### rtl/circle_span_and_point_rasterizer.sv
// Top level of the circle span and point rasterizer.
// Joins the queueing front end and the span back end; depends on cspr_pkg,
// cspr_if, cspr_front and cspr_back.
//
// Usage: send a start beat (kind 0) with centre, radius and fill flag, then
// one next beat (kind 1) per wanted span. Each next beat gives exactly one
// span beat; start beats give none. Outline circles yield eight one-pixel
// spans per step, filled discs four horizontal spans per step, and the beat
// that ends the circle carries last. A next beat with no circle in progress
// returns a beat with valid_res low and zero fields. Throughput is one beat
// per clock in both directions while the output is not stalled: the back end
// forms a whole step output, decision update included, combinationally. An
// accepted next beat passes through the two-entry command queue and then the
// output register to its span, and waits longer while the output stalls.
`default_nettype none

module circle_span_and_point_rasterizer
  import cspr_pkg::*;
#(
  parameter int COORD_BITS = CSPR_COORD_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  cspr_in_if.sink   item,
  cspr_out_if.source span
);

  logic                         cmd_valid;
  logic                         cmd_ready;
  op_t                          cmd_op;
  logic signed [COORD_BITS-1:0] cmd_cx;
  logic signed [COORD_BITS-1:0] cmd_cy;
  logic        [COORD_BITS-2:0] cmd_rad;
  logic                         cmd_fill;

  // Accept and queue commands
  cspr_front #(
    .COORD_BITS (COORD_BITS),
    .QUEUE_DEPTH(CSPR_QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_op   (cmd_op),
    .cmd_cx   (cmd_cx),
    .cmd_cy   (cmd_cy),
    .cmd_rad  (cmd_rad),
    .cmd_fill (cmd_fill)
  );

  // Generate spans
  cspr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_op   (cmd_op),
    .cmd_cx   (cmd_cx),
    .cmd_cy   (cmd_cy),
    .cmd_rad  (cmd_rad),
    .cmd_fill (cmd_fill),
    .span     (span)
  );

endmodule

`default_nettype wire

### rtl/cspr_front.sv
// Front end: accepts input beats, tags them as start or next commands
// and queues them for the back end. Depends on cspr_pkg and cspr_if.
`default_nettype none

module cspr_front
  import cspr_pkg::*;
#(
  parameter int COORD_BITS  = CSPR_COORD_BITS,
  parameter int QUEUE_DEPTH = CSPR_QUEUE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  cspr_in_if.sink                           item,
  output      logic                         cmd_valid,
  input  wire logic                         cmd_ready,
  output      op_t                          cmd_op,
  output      logic signed [COORD_BITS-1:0] cmd_cx,
  output      logic signed [COORD_BITS-1:0] cmd_cy,
  output      logic        [COORD_BITS-2:0] cmd_rad,
  output      logic                         cmd_fill
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_END = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

  // Queue storage, payload only
  op_t                         q_op   [QUEUE_DEPTH];
  logic signed [COORD_BITS-1:0] q_cx  [QUEUE_DEPTH];
  logic signed [COORD_BITS-1:0] q_cy  [QUEUE_DEPTH];
  logic        [COORD_BITS-2:0] q_rad [QUEUE_DEPTH];
  logic                         q_fill[QUEUE_DEPTH];

  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                push;
  logic                pop;
  op_t                 in_op;

  // Classify the incoming beat
  assign in_op = item.kind ? OP_NEXT : OP_START;

  assign item.ready = (count != CNT_FULL);
  assign push       = item.valid && item.ready;
  assign cmd_valid  = (count != '0);
  assign pop        = cmd_valid && cmd_ready;

  // Write the tail entry
  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]   <= in_op;
      q_cx[wr_ptr]   <= item.center_x;
      q_cy[wr_ptr]   <= item.center_y;
      q_rad[wr_ptr]  <= item.circle_radius;
      q_fill[wr_ptr] <= item.filled;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_END) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_END) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Present the head entry
  assign cmd_op   = q_op[rd_ptr];
  assign cmd_cx   = q_cx[rd_ptr];
  assign cmd_cy   = q_cy[rd_ptr];
  assign cmd_rad  = q_rad[rd_ptr];
  assign cmd_fill = q_fill[rd_ptr];

endmodule

`default_nettype wire

### rtl/cspr_back.sv
// Back end: holds the circle state, runs the midpoint-style decision
// step and registers one span per next command. Depends on cspr_pkg, cspr_if.
`default_nettype none

module cspr_back
  import cspr_pkg::*;
#(
  parameter int COORD_BITS = CSPR_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cmd_valid,
  output      logic                         cmd_ready,
  input  wire op_t                          cmd_op,
  input  wire logic signed [COORD_BITS-1:0] cmd_cx,
  input  wire logic signed [COORD_BITS-1:0] cmd_cy,
  input  wire logic        [COORD_BITS-2:0] cmd_rad,
  input  wire logic                         cmd_fill,
  cspr_out_if.source                        span
);

  localparam int RAD_BITS = COORD_BITS - 1;
  localparam int OUT_BITS = COORD_BITS + 1;
  localparam int DEC_BITS = COORD_BITS + 2;

  // Circle state
  logic signed [COORD_BITS-1:0] centre_col;
  logic signed [COORD_BITS-1:0] centre_row;
  logic        [RAD_BITS-1:0]   radius_held;
  logic                         fill_mode;
  logic        [RAD_BITS-1:0]   offset_a;
  logic        [RAD_BITS-1:0]   offset_b;
  logic signed [DEC_BITS-1:0]   decision;
  logic        [2:0]            emit_index;
  logic                         active;

  // Output register
  logic                       out_valid;
  logic signed [OUT_BITS-1:0] out_xl;
  logic signed [OUT_BITS-1:0] out_xr;
  logic signed [OUT_BITS-1:0] out_row;
  logic                       out_res;
  logic                       out_last;

  logic fire;
  logic out_free;
  logic do_next;

  // Step datapath
  logic [1:0]                 kf;
  logic [RAD_BITS-1:0]        col_mag;
  logic [RAD_BITS-1:0]        row_mag;
  logic                       col_neg;
  logic                       row_neg;
  logic signed [OUT_BITS-1:0] cc_ext;
  logic signed [OUT_BITS-1:0] cr_ext;
  logic signed [OUT_BITS-1:0] col_ext;
  logic signed [OUT_BITS-1:0] row_ext;
  logic signed [OUT_BITS-1:0] col_lo;
  logic signed [OUT_BITS-1:0] col_hi;
  logic signed [OUT_BITS-1:0] xl;
  logic signed [OUT_BITS-1:0] xr;
  logic signed [OUT_BITS-1:0] row;
  logic                       step_end;

  // Decision update
  logic signed [DEC_BITS-1:0] two_a;
  logic signed [DEC_BITS-1:0] two_b;
  logic signed [DEC_BITS-1:0] two_rb;
  logic        [RAD_BITS-1:0] r_minus_b;
  logic                       move_a;
  logic                       move_b;
  logic        [RAD_BITS:0]   a_wide;
  logic        [RAD_BITS:0]   b_wide;
  logic signed [DEC_BITS-1:0] decision_next;
  logic        [RAD_BITS-1:0] offset_a_next;
  logic        [RAD_BITS-1:0] offset_b_next;
  logic                       fin;

  // Handshake: a start never waits for the output slot
  assign out_free  = !out_valid || span.ready;
  assign cmd_ready = (cmd_op == OP_START) || out_free;
  assign fire      = cmd_valid && cmd_ready;
  assign do_next   = fire && (cmd_op == OP_NEXT);

  // Pick offsets and signs for the current output of the step
  always_comb begin
    kf = emit_index[1:0];
    if (fill_mode) begin
      col_mag  = SP_W_SEL[kf]   ? offset_b : offset_a;
      row_mag  = SP_ROW_SEL[kf] ? offset_b : offset_a;
      col_neg  = 1'b1;
      row_neg  = SP_ROW_NEG[kf];
      step_end = (kf == SP_LAST);
    end else begin
      col_mag  = PT_COL_SEL[emit_index] ? offset_b : offset_a;
      row_mag  = PT_ROW_SEL[emit_index] ? offset_b : offset_a;
      col_neg  = PT_COL_NEG[emit_index];
      row_neg  = PT_ROW_NEG[emit_index];
      step_end = (emit_index == PT_LAST);
    end
  end

  // Form the span ends and row
  always_comb begin
    cc_ext  = OUT_BITS'(centre_col);
    cr_ext  = OUT_BITS'(centre_row);
    col_ext = $signed({2'b00, col_mag});
    row_ext = $signed({2'b00, row_mag});
    col_lo  = cc_ext - col_ext;
    col_hi  = cc_ext + col_ext;
    xl      = (fill_mode || col_neg) ? col_lo : col_hi;
    xr      = fill_mode ? col_hi : xl;
    row     = row_neg ? (cr_ext - row_ext) : (cr_ext + row_ext);
  end

  // Decision step: diagonal unless one offset alone keeps to the circle
  always_comb begin
    r_minus_b = radius_held - offset_b;
    two_a     = $signed({2'b00, offset_a, 1'b0});
    two_b     = $signed({2'b00, offset_b, 1'b0});
    two_rb    = $signed({2'b00, r_minus_b, 1'b0});
    move_a    = (decision >= two_a);
    move_b    = (decision < two_rb);
    a_wide    = {1'b0, offset_a};
    b_wide    = {1'b0, offset_b};
    offset_a_next = offset_a + 1'b1;
    offset_b_next = offset_b - 1'b1;
    if (move_a) begin
      decision_next = decision - two_a - DEC_BITS'(1);
      offset_b_next = offset_b;
      fin           = (b_wide <= a_wide);
    end else if (move_b) begin
      decision_next = decision + two_b - DEC_BITS'(1);
      offset_a_next = offset_a;
      fin           = (b_wide <= a_wide);
    end else begin
      decision_next = decision + two_b - two_a - DEC_BITS'(2);
      fin           = (b_wide <= (a_wide + 1'b1));
    end
  end

  // Circle state: load on start, advance on each next while active
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_col  <= '0;
      centre_row  <= '0;
      radius_held <= '0;
      fill_mode   <= 1'b0;
      offset_a    <= '0;
      offset_b    <= '0;
      decision    <= '0;
      emit_index  <= '0;
      active      <= 1'b0;
    end else if (fire && (cmd_op == OP_START)) begin
      centre_col  <= cmd_cx;
      centre_row  <= cmd_cy;
      radius_held <= cmd_rad;
      fill_mode   <= cmd_fill;
      offset_a    <= '0;
      offset_b    <= cmd_rad;
      decision    <= $signed({3'b000, cmd_rad}) - DEC_BITS'(1);
      emit_index  <= '0;
      active      <= 1'b1;
    end else if (do_next && active) begin
      if (step_end) begin
        emit_index <= '0;
        offset_a   <= offset_a_next;
        offset_b   <= offset_b_next;
        decision   <= decision_next;
        if (fin) begin
          active <= 1'b0;
        end
      end else begin
        emit_index <= emit_index + 1'b1;
      end
    end
  end

  // Output valid: set on a next, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_next) begin
      out_valid <= 1'b1;
    end else if (span.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload; an idle rasterizer gives an empty beat
  always_ff @(posedge clk) begin
    if (do_next) begin
      if (active) begin
        out_xl   <= xl;
        out_xr   <= xr;
        out_row  <= row;
        out_res  <= 1'b1;
        out_last <= step_end && fin;
      end else begin
        out_xl   <= '0;
        out_xr   <= '0;
        out_row  <= '0;
        out_res  <= 1'b0;
        out_last <= 1'b0;
      end
    end
  end

  assign span.valid     = out_valid;
  assign span.x_left    = out_xl;
  assign span.x_right   = out_xr;
  assign span.span_row  = out_row;
  assign span.valid_res = out_res;
  assign span.last      = out_last;

endmodule

`default_nettype wire

### rtl/cspr_checker.sv
// Port checker for the circle span and point rasterizer, bound to the top.
// Watches the span channel only; depends on cspr_pkg.
`default_nettype none

module cspr_checker
  import cspr_pkg::*;
#(
  parameter int COORD_BITS = CSPR_COORD_BITS
) (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       valid,
  input wire logic                       ready,
  input wire logic signed [COORD_BITS:0] x_left,
  input wire logic signed [COORD_BITS:0] x_right,
  input wire logic signed [COORD_BITS:0] span_row,
  input wire logic                       valid_res,
  input wire logic                       last
);

  // No span beat straight out of reset
  assert property (@(posedge clk) rst |=> !valid)
    else $error("span beat offered right after reset");

  // A stalled beat holds its payload
  assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(x_left) && $stable(x_right)
      && $stable(span_row) && $stable(valid_res) && $stable(last))
    else $error("stalled span beat changed");

  // An empty beat carries zero fields and never ends a circle
  assert property (@(posedge clk) disable iff (rst)
    valid && !valid_res |-> x_left == '0 && x_right == '0 && span_row == '0 && !last)
    else $error("empty beat with non-zero fields");

  // Span ends are ordered
  assert property (@(posedge clk) disable iff (rst)
    valid && valid_res |-> x_left <= x_right)
    else $error("span left end beyond right end");

endmodule

bind circle_span_and_point_rasterizer cspr_checker #(
  .COORD_BITS(COORD_BITS)
) u_cspr_checker (
  .clk      (clk),
  .rst      (rst),
  .valid    (span.valid),
  .ready    (span.ready),
  .x_left   (span.x_left),
  .x_right  (span.x_right),
  .span_row (span.span_row),
  .valid_res(span.valid_res),
  .last     (span.last)
);

`default_nettype wire
